[rtl/bse_pkg.sv]
// Shared types, constants and cell control codes for the bubble sort engine.
`timescale 1ns / 1ps
package bse_pkg;

	localparam int DATA_W           = 32;
	localparam int MAX_ELEMENTS_DEF = 16;

	// cell operating modes
	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_SORT = 2'd2;
	localparam logic [1:0] MODE_EMIT = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     is_final;
		logic                     overflow;
	} out_word_t;

	// one cell entry: occupied flag plus element
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] val;
	} ent_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic [1:0] mode;
		logic       pair_up;
		logic       pair_dn;
	} ctl_t;

endpackage

[rtl/bse_cell.sv]
// One sorter cell: holds one entry, shifts or compare-exchanges with a neighbor.
`timescale 1ns / 1ps
module bse_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  bse_pkg::ctl_t ctl,
	input  bse_pkg::ent_t prv,
	input  bse_pkg::ent_t nxt,
	output bse_pkg::ent_t ent
);
	import bse_pkg::*;

	logic                     vld_q;
	logic signed [DATA_W-1:0] val_q;
	ent_t                     cur;
	ent_t                     ent_d;

	assign cur = {vld_q, val_q};

	always_comb begin
		ent_d = cur;
		unique case (ctl.mode)
			MODE_HOLD: ent_d = cur;
			MODE_LOAD: ent_d = prv;
			MODE_EMIT: ent_d = nxt;
			MODE_SORT: begin
				// keep the smaller value on the low side; equal values stay put
				if (ctl.pair_up && cur.vld && nxt.vld && (cur.val > nxt.val)) begin
					ent_d = nxt;
				end else if (ctl.pair_dn && prv.vld && cur.vld
					&& (prv.val > cur.val)) begin
					ent_d = prv;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= ent_d.vld;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= ent_d.val;
	end

	assign ent = cur;

endmodule

[rtl/bubble_sort_engine_top.sv]
// Top level of the bubble sort engine: cell row plus load/sort/emit sequencer.
`timescale 1ns / 1ps
// A list is loaded one word per cycle while busy is low (start high accepts a word);
// the word with is_last set closes the list. The engine then raises busy, runs
// MAX_ELEMENTS odd-even transposition passes over the row of cells (one pass per
// cycle), and emits the n stored words in ascending signed order, one per cycle on
// result with result_strobe high, is_final on the last one. Busy drops in the
// cycle after the final word. The receiver cannot stall: each result is shown for
// exactly one cycle. Words past MAX_ELEMENTS are dropped and every result of that
// list carries overflow.
module bubble_sort_engine_top #(
	parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bse_pkg::in_word_t  item,
	output logic               result_strobe,
	output bse_pkg::out_word_t result
);
	import bse_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int PASS_W = $clog2(MAX_ELEMENTS);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [PASS_W-1:0] pass_q;
	logic              ovf_q;

	logic       accept;
	logic       room;
	logic [1:0] mode;
	ent_t       load_ent;

	ent_t cells   [MAX_ELEMENTS];
	ent_t prv_ent [MAX_ELEMENTS];
	ent_t nxt_ent [MAX_ELEMENTS];

	assign busy   = (state_q != ST_LOAD);
	assign accept = start && !busy;
	assign room   = (count_q < CNT_W'(MAX_ELEMENTS));

	assign load_ent.vld = 1'b1;
	assign load_ent.val = item.value;

	// load shifts the row up from cell 0, emit shifts it down toward cell 0
	always_comb begin
		mode = MODE_HOLD;
		unique case (state_q)
			ST_LOAD: mode = (accept && room) ? MODE_LOAD : MODE_HOLD;
			ST_SORT: mode = MODE_SORT;
			ST_EMIT: mode = MODE_EMIT;
			default: mode = MODE_HOLD;
		endcase
	end

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		localparam logic I_ODD  = 1'(i % 2);
		localparam logic HAS_UP = (i + 1 < MAX_ELEMENTS);
		localparam logic HAS_DN = (i > 0);
		ctl_t ctl;

		// even passes pair (0,1),(2,3)..; odd passes pair (1,2),(3,4)..
		assign ctl.mode    = mode;
		assign ctl.pair_up = HAS_UP && (pass_q[0] == I_ODD);
		assign ctl.pair_dn = HAS_DN && (pass_q[0] != I_ODD);

		if (i == 0) begin : g_first
			assign prv_ent[i] = load_ent;
		end else begin : g_mid_p
			assign prv_ent[i] = cells[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_last
			assign nxt_ent[i] = '0;
		end else begin : g_mid_n
			assign nxt_ent[i] = cells[i+1];
		end

		bse_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prv    (prv_ent[i]),
			.nxt    (nxt_ent[i]),
			.ent    (cells[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			pass_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.is_last) begin
							state_q <= ST_SORT;
							pass_q  <= '0;
						end
					end
				end
				ST_SORT: begin
					if (pass_q == PASS_W'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_EMIT;
					end
					pass_q <= pass_q + PASS_W'(1);
				end
				ST_EMIT: begin
					// final word leaves when the cell behind cell 0 is empty
					if (!cells[1].vld) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign result_strobe       = (state_q == ST_EMIT);
	assign result.sorted_value = cells[0].val;
	assign result.is_final     = !cells[1].vld;
	assign result.overflow     = ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond capacity");

	a_emit_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> cells[0].vld)
		else $error("word emitted from an empty cell");

	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.is_final |=> !busy && (count_q == '0))
		else $error("engine not free after final word");

	a_sort_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_strobe) |-> $past(state_q) == ST_SORT)
		else $error("emit entered without sorting");
`endif

endmodule
